/* rtl/hbdsn_pkg.sv */
// hbdsn_pkg: types and constants of the heatmap box decoder with soft suppression
// used by heatmap_box_decode_soft_nms, no dependencies
package hbdsn_pkg;

   localparam int unsigned DIV_STEPS = 17;
   localparam logic [16:0] ONE_Q16 = 17'd65536;
   localparam logic signed [18:0] PIX_ONE = 19'sd16;

   typedef enum logic [1:0] {
      CSR_SCORE_THR = 2'd0,
      CSR_OVL_THR   = 2'd1,
      CSR_MAP_WIDTH = 2'd2,
      CSR_STRIDE    = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic signed [16:0] left;
      logic signed [16:0] top;
      logic signed [16:0] right;
      logic signed [16:0] bottom;
      logic [15:0]        score;
      logic               label;
   } entry_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_INS_RD, ST_INS_CHK, ST_INS_PUT,
      ST_NI, ST_NIL, ST_NJ, ST_NJL, ST_MUL, ST_UNI, ST_CHK, ST_DIV, ST_CMP, ST_DEC, ST_RM,
      ST_ERD, ST_ELD, ST_EEND
   } state_type;

   function automatic logic signed [16:0] sat17(input logic signed [19:0] v);
      logic signed [16:0] r;
      if (v < -20'sd65536) begin
         r = -17'sd65536;
      end else if (v > 20'sd65535) begin
         r = 17'sd65535;
      end else begin
         r = v[16:0];
      end
      return r;
   endfunction

endpackage

/* rtl/heatmap_box_decode_soft_nms.sv */
// heatmap_box_decode_soft_nms: box decoder, sorted box store and linear soft suppression
// depends on hbdsn_pkg
//
//  channel | dir | handshake            | payload
//  req     | in  | req_tvalid/tready    | tdata scores and distances, tlast last location
//  rsp     | out | rsp_tvalid/tready    | tdata box corners and score, tuser flags, tlast
//  csr     | in  | csr_we               | csr_addr, csr_wdata
//
// a location with no candidate is taken in ST_IDLE alone; a candidate is compared with the
// store entries one by one through the single store read port, then written in ST_INS_PUT
// suppression takes each live pair through ST_NJ, ST_NJL, ST_MUL, ST_UNI, ST_CHK, ST_RM, with
// ST_DIV (one quotient bit a cycle), ST_CMP, ST_DEC between as needed; the 19x19 multiplier
// is shared by areas and decay; results leave through one output register; rsp stalls hold it
// reset is synchronous and clears control state only; store contents are not cleared
module heatmap_box_decode_soft_nms
   import hbdsn_pkg::*;
#(
   parameter int MAX_BOXES     = 64,
   parameter int MAX_MAP_WIDTH = 256
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // score_class0, score_class1, dist_left, dist_top, dist_right, dist_bottom
   input  logic [95:0]  req_tdata,
   input  logic         req_tlast,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // box_left, box_top, box_right, box_bottom, box_score, zero pad
   output logic [87:0]  rsp_tdata,
   // box_label, box_valid, store_overflow
   output logic [2:0]   rsp_tuser,
   output logic         rsp_tlast,
   input  logic         csr_we,
   input  logic [1:0]   csr_addr,
   input  logic [15:0]  csr_wdata
);

   localparam int IW = $clog2(MAX_BOXES);
   localparam int CW = $clog2(MAX_BOXES + 1);
   localparam logic [CW-1:0] CMAX = CW'(MAX_BOXES);
   localparam logic [8:0] MW = 9'(MAX_MAP_WIDTH);

   entry_type mem [MAX_BOXES];
   entry_type mem_rd_ff;
   logic mem_we;
   logic [IW-1:0] mem_wa, mem_ra;
   entry_type mem_wd;

   logic [15:0] score_thr_ff, ovl_thr_ff;
   logic [8:0]  map_w_ff;
   logic [5:0]  stride_ff;

   state_type state_ff, state_in;
   logic [7:0] row_ff, row_in, col_ff, col_in;
   logic [CW-1:0] cnt_ff, cnt_in, rmv_ff, rmv_in, k_ff, k_in, i_ff, i_in, j_ff, j_in;
   logic [CW-1:0] emit_ff, emit_in;
   logic ovf_ff, ovf_in, last_ff, last_in, upd_ff, upd_in;
   logic [MAX_BOXES-1:0] dead_ff, dead_in;
   entry_type cand_ff, cand_in, ei_ff, ei_in, ej_ff, ej_in;
   logic signed [18:0] iw_ff, iw_in, ih_ff, ih_in, wi_ff, wi_in, hi_ff, hi_in;
   logic signed [18:0] wj_ff, wj_in, hj_ff, hj_in;
   logic [1:0] mstep_ff, mstep_in;
   logic signed [37:0] inter_ff, inter_in, ai_ff, ai_in, aj_ff, aj_in;
   logic signed [39:0] uni_ff, uni_in;
   logic [39:0] rem_ff, rem_in;
   logic [16:0] q_ff, q_in, ovr_ff, ovr_in;
   logic [4:0] dcnt_ff, dcnt_in;
   logic [15:0] sc_ff, sc_in;

   logic rsp_valid_ff, rsp_valid_in, rsp_box_ff, rsp_box_in, rsp_ovf_ff, rsp_ovf_in;
   logic rsp_last_ff, rsp_last_in;
   entry_type rsp_data_ff, rsp_data_in;

   // combinational helpers
   logic signed [18:0] mul_a, mul_b;
   logic signed [37:0] mul_p;
   logic [15:0] s0, s1, best;
   logic [13:0] cprod;
   logic signed [19:0] cx, cy;
   logic [8:0] w_eff;
   logic out_free, after, cond;
   logic signed [18:0] li, ti, ri, bi, lj, tj, rj, bj, mnr, mxl, mnb, mxt, iw_raw, ih_raw;
   logic [40:0] tdiv, uni_u;

   assign mul_p = mul_a * mul_b;
   assign out_free = !rsp_valid_ff || rsp_tready;

   // store
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      mem_rd_ff <= mem[mem_ra];
   end

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         score_thr_ff <= 16'd32768;
         ovl_thr_ff   <= 16'd26214;
         map_w_ff     <= 9'd80;
         stride_ff    <= 6'd4;
      end else if (csr_we) begin
         case (csr_index_type'(csr_addr))
            CSR_SCORE_THR: score_thr_ff <= csr_wdata;
            CSR_OVL_THR:   ovl_thr_ff   <= csr_wdata;
            CSR_MAP_WIDTH: map_w_ff     <= csr_wdata[8:0];
            CSR_STRIDE:    stride_ff    <= csr_wdata[5:0];
            default:       score_thr_ff <= score_thr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         row_ff       <= '0;
         col_ff       <= '0;
         cnt_ff       <= '0;
         rmv_ff       <= '0;
         ovf_ff       <= 1'b0;
         dead_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         cnt_ff       <= cnt_in;
         rmv_ff       <= rmv_in;
         ovf_ff       <= ovf_in;
         dead_ff      <= dead_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      k_ff        <= k_in;
      i_ff        <= i_in;
      j_ff        <= j_in;
      emit_ff     <= emit_in;
      last_ff     <= last_in;
      upd_ff      <= upd_in;
      cand_ff     <= cand_in;
      ei_ff       <= ei_in;
      ej_ff       <= ej_in;
      iw_ff       <= iw_in;
      ih_ff       <= ih_in;
      wi_ff       <= wi_in;
      hi_ff       <= hi_in;
      wj_ff       <= wj_in;
      hj_ff       <= hj_in;
      mstep_ff    <= mstep_in;
      inter_ff    <= inter_in;
      ai_ff       <= ai_in;
      aj_ff       <= aj_in;
      uni_ff      <= uni_in;
      rem_ff      <= rem_in;
      q_ff        <= q_in;
      ovr_ff      <= ovr_in;
      dcnt_ff     <= dcnt_in;
      sc_ff       <= sc_in;
      rsp_box_ff  <= rsp_box_in;
      rsp_ovf_ff  <= rsp_ovf_in;
      rsp_last_ff <= rsp_last_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      // decode of the incoming word
      s0    = req_tdata[15:0];
      s1    = req_tdata[31:16];
      best  = (s0 > s1) ? s0 : s1;
      cprod = 14'(col_ff) * 14'(stride_ff);
      cx    = signed'({2'b00, cprod, 4'b0000});
      cprod = 14'(row_ff) * 14'(stride_ff);
      cy    = signed'({2'b00, cprod, 4'b0000});
      w_eff = (map_w_ff == 9'd0) ? 9'd1 : ((map_w_ff > MW) ? MW : map_w_ff);

      // pair geometry
      li  = 19'(ei_ff.left);
      ti  = 19'(ei_ff.top);
      ri  = 19'(ei_ff.right);
      bi  = 19'(ei_ff.bottom);
      lj  = 19'(mem_rd_ff.left);
      tj  = 19'(mem_rd_ff.top);
      rj  = 19'(mem_rd_ff.right);
      bj  = 19'(mem_rd_ff.bottom);
      mnr = (ri < rj) ? ri : rj;
      mxl = (li > lj) ? li : lj;
      mnb = (bi < bj) ? bi : bj;
      mxt = (ti > tj) ? ti : tj;
      iw_raw = mnr - mxl + PIX_ONE;
      ih_raw = mnb - mxt + PIX_ONE;

      after = (mem_rd_ff.score < cand_ff.score) ||
              (mem_rd_ff.score == cand_ff.score && mem_rd_ff.label > cand_ff.label);

      uni_u = {1'b0, uni_ff};
      tdiv  = {rem_ff, (dcnt_ff == 5'd0) ? inter_ff[0] : 1'b0};
      cond  = (q_ff > {1'b0, ovl_thr_ff}) || (q_ff == {1'b0, ovl_thr_ff} && rem_ff != '0);

      mul_a = iw_ff;
      mul_b = ih_ff;

      state_in = state_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      cnt_in   = cnt_ff;
      rmv_in   = rmv_ff;
      ovf_in   = ovf_ff;
      dead_in  = dead_ff;
      k_in     = k_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      emit_in  = emit_ff;
      last_in  = last_ff;
      upd_in   = upd_ff;
      cand_in  = cand_ff;
      ei_in    = ei_ff;
      ej_in    = ej_ff;
      iw_in    = iw_ff;
      ih_in    = ih_ff;
      wi_in    = wi_ff;
      hi_in    = hi_ff;
      wj_in    = wj_ff;
      hj_in    = hj_ff;
      mstep_in = mstep_ff;
      inter_in = inter_ff;
      ai_in    = ai_ff;
      aj_in    = aj_ff;
      uni_in   = uni_ff;
      rem_in   = rem_ff;
      q_in     = q_ff;
      ovr_in   = ovr_ff;
      dcnt_in  = dcnt_ff;
      sc_in    = sc_ff;

      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_box_in   = rsp_box_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_data_in  = rsp_data_ff;

      mem_we = 1'b0;
      mem_wa = k_ff[IW-1:0];
      mem_wd = cand_ff;
      mem_ra = k_ff[IW-1:0];
      req_tready = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cand_in.left   = sat17(cx - 20'(signed'(req_tdata[47:32])));
               cand_in.top    = sat17(cy - 20'(signed'(req_tdata[63:48])));
               cand_in.right  = sat17(cx + 20'(signed'(req_tdata[79:64])));
               cand_in.bottom = sat17(cy + 20'(signed'(req_tdata[95:80])));
               cand_in.score  = best;
               cand_in.label  = !(s0 > s1);
               last_in = req_tlast;
               if ({1'b0, col_ff} + 9'd1 >= w_eff) begin
                  col_in = '0;
                  row_in = row_ff + 8'd1;
               end else begin
                  col_in = col_ff + 8'd1;
               end
               i_in = '0;
               if (best > score_thr_ff) begin
                  if (cnt_ff == CMAX) begin
                     ovf_in = 1'b1;
                  end
                  if (cnt_ff == '0) begin
                     k_in = '0;
                     state_in = ST_INS_PUT;
                  end else begin
                     k_in = cnt_ff - CW'(1);
                     state_in = ST_INS_RD;
                  end
               end else if (req_tlast) begin
                  state_in = ST_NI;
               end
            end
         end
         ST_INS_RD: begin
            state_in = ST_INS_CHK;
         end
         ST_INS_CHK: begin
            if (after) begin
               // entry moves up one place, the top one falls off a full store
               if (k_ff + CW'(1) < CMAX) begin
                  mem_we = 1'b1;
                  mem_wa = IW'(k_ff + CW'(1));
                  mem_wd = mem_rd_ff;
               end
               if (k_ff == '0) begin
                  state_in = ST_INS_PUT;
               end else begin
                  k_in = k_ff - CW'(1);
                  state_in = ST_INS_RD;
               end
            end else begin
               k_in = k_ff + CW'(1);
               state_in = ST_INS_PUT;
            end
         end
         ST_INS_PUT: begin
            if (k_ff < CMAX) begin
               mem_we = 1'b1;
               if (cnt_ff != CMAX) begin
                  cnt_in = cnt_ff + CW'(1);
               end
            end
            state_in = last_ff ? ST_NI : ST_IDLE;
         end
         ST_NI: begin
            mem_ra = i_ff[IW-1:0];
            if (i_ff >= cnt_ff) begin
               k_in = '0;
               emit_in = '0;
               state_in = ST_ERD;
            end else if (dead_ff[i_ff[IW-1:0]]) begin
               i_in = i_ff + CW'(1);
            end else begin
               state_in = ST_NIL;
            end
         end
         ST_NIL: begin
            ei_in = mem_rd_ff;
            j_in = i_ff + CW'(1);
            state_in = ST_NJ;
         end
         ST_NJ: begin
            mem_ra = j_ff[IW-1:0];
            if (j_ff >= cnt_ff) begin
               i_in = i_ff + CW'(1);
               state_in = ST_NI;
            end else if (dead_ff[j_ff[IW-1:0]]) begin
               j_in = j_ff + CW'(1);
            end else begin
               state_in = ST_NJL;
            end
         end
         ST_NJL: begin
            ej_in = mem_rd_ff;
            sc_in = mem_rd_ff.score;
            upd_in = 1'b0;
            iw_in = (iw_raw < 0) ? '0 : iw_raw;
            ih_in = (ih_raw < 0) ? '0 : ih_raw;
            wi_in = ri - li + PIX_ONE;
            hi_in = bi - ti + PIX_ONE;
            wj_in = rj - lj + PIX_ONE;
            hj_in = bj - tj + PIX_ONE;
            mstep_in = 2'd0;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            case (mstep_ff)
               2'd0: begin
                  inter_in = mul_p;
               end
               2'd1: begin
                  mul_a = wi_ff;
                  mul_b = hi_ff;
                  ai_in = mul_p;
               end
               default: begin
                  mul_a = wj_ff;
                  mul_b = hj_ff;
                  aj_in = mul_p;
                  state_in = ST_UNI;
               end
            endcase
            mstep_in = mstep_ff + 2'd1;
         end
         ST_UNI: begin
            uni_in = 40'(ai_ff) + 40'(aj_ff) - 40'(inter_ff);
            state_in = ST_CHK;
         end
         ST_CHK: begin
            if (uni_ff <= 0) begin
               state_in = ST_RM;
            end else if ({3'b000, inter_ff} >= {uni_ff, 1'b0}) begin
               // quotient beyond 17 bits: overlap is full
               ovr_in = ONE_Q16;
               state_in = ST_DEC;
            end else begin
               rem_in = 40'(inter_ff[37:1]);
               q_in = '0;
               dcnt_in = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (tdiv >= uni_u) begin
               rem_in = 40'(tdiv - uni_u);
               q_in = {q_ff[15:0], 1'b1};
            end else begin
               rem_in = tdiv[39:0];
               q_in = {q_ff[15:0], 1'b0};
            end
            dcnt_in = dcnt_ff + 5'd1;
            if (dcnt_ff == 5'(DIV_STEPS - 1)) begin
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            if (cond) begin
               ovr_in = (q_ff > ONE_Q16) ? ONE_Q16 : q_ff;
               state_in = ST_DEC;
            end else begin
               state_in = ST_RM;
            end
         end
         ST_DEC: begin
            mul_a = signed'({3'b000, sc_ff});
            mul_b = signed'({2'b00, ONE_Q16 - ovr_ff});
            sc_in = mul_p[31:16];
            upd_in = 1'b1;
            state_in = ST_RM;
         end
         ST_RM: begin
            if (sc_ff < score_thr_ff) begin
               dead_in[j_ff[IW-1:0]] = 1'b1;
               rmv_in = rmv_ff + CW'(1);
            end else if (upd_ff) begin
               mem_we = 1'b1;
               mem_wa = j_ff[IW-1:0];
               mem_wd = ej_ff;
               mem_wd.score = sc_ff;
            end
            j_in = j_ff + CW'(1);
            state_in = ST_NJ;
         end
         ST_ERD: begin
            if (k_ff >= cnt_ff) begin
               state_in = ST_EEND;
            end else if (dead_ff[k_ff[IW-1:0]]) begin
               k_in = k_ff + CW'(1);
            end else begin
               state_in = ST_ELD;
            end
         end
         ST_ELD: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = mem_rd_ff;
               rsp_box_in   = 1'b1;
               rsp_ovf_in   = ovf_ff;
               rsp_last_in  = (emit_ff + CW'(1) == cnt_ff - rmv_ff);
               emit_in = emit_ff + CW'(1);
               k_in = k_ff + CW'(1);
               state_in = ST_ERD;
            end
         end
         ST_EEND: begin
            if (emit_ff != '0 || out_free) begin
               if (emit_ff == '0) begin
                  // nothing survived: one empty word
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = '0;
                  rsp_box_in   = 1'b0;
                  rsp_ovf_in   = ovf_ff;
                  rsp_last_in  = 1'b1;
               end
               cnt_in  = '0;
               rmv_in  = '0;
               row_in  = '0;
               col_in  = '0;
               ovf_in  = 1'b0;
               dead_in = '0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_data_ff.score, rsp_data_ff.bottom, rsp_data_ff.right,
                        rsp_data_ff.top, rsp_data_ff.left};
   assign rsp_tuser  = {rsp_ovf_ff, rsp_box_ff, rsp_data_ff.label};
   assign rsp_tlast  = rsp_last_ff;

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CMAX && rmv_ff <= cnt_ff)
      else $error("store count out of range");

   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_box_ff |-> rsp_last_ff)
      else $error("empty word not marked last");

   a_last_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> !req_tready)
      else $error("new location taken before suppression");

   a_div_uni: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> uni_ff > 0 && rem_ff < uni_ff[39:0])
      else $error("division remainder not below divisor");

endmodule

/* bench/tb_top.sv */
// tb_top: self-checking bench for heatmap_box_decode_soft_nms, box decode and soft suppression
// depends on hbdsn_pkg and the rtl top; predicts every box word and compares field by field
`timescale 1ns / 100ps

module tb_top;
   import hbdsn_pkg::*;

   localparam int NBOX = 64;
   localparam int WATCH_LIMIT = 400000;

   typedef struct {
      logic [95:0] data;
      logic        last;
   } loc_item;

   typedef struct {
      logic [87:0] data;
      logic [2:0]  user;
      logic        last;
   } box_word;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [95:0] req_tdata = '0;
   logic        req_tlast = 0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [87:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_we = 0;
   logic [1:0]  csr_addr = '0;
   logic [15:0] csr_wdata = '0;

   heatmap_box_decode_soft_nms dut (.*);

   always #6 clock = ~clock;

   // predictor state
   int unsigned thr_score, thr_ovl, width_cfg, stride_cfg;
   int unsigned row_cnt, col_cnt, n_boxes;
   bit          ovf_seen;
   int          bl[NBOX], bt[NBOX], br[NBOX], bb[NBOX];
   int unsigned bw[NBOX], bc[NBOX];

   loc_item     pending_locs[$];
   box_word     expected_boxes[$];
   int          errors = 0, mismatches = 0, maps_done = 0, boxes_seen = 0;
   bit          tx_quiet = 0;
   bit          hold_arm = 0, hold_used = 0;
   int          hold_left = 0;
   logic        rx_hold;
   int          watch = 0;

   assign rx_hold = (hold_left != 0);

   function automatic int clip17(longint v);
      if (v < -65536) return -65536;
      if (v > 65535) return 65535;
      return int'(v);
   endfunction

   function automatic longint box_area(int k);
      return longint'(br[k] - bl[k] + 16) * longint'(bb[k] - bt[k] + 16);
   endfunction

   task automatic drop_box(int k);
      for (int m = k; m < n_boxes - 1; m++) begin
         bl[m] = bl[m+1]; bt[m] = bt[m+1]; br[m] = br[m+1]; bb[m] = bb[m+1];
         bw[m] = bw[m+1]; bc[m] = bc[m+1];
      end
      n_boxes--;
   endtask

   task automatic decode_location(loc_item it);
      int unsigned s0, s1, best, lab, p, w;
      longint cx, cy;
      logic signed [15:0] dl, dt, dr, db;
      longint iw, ih, inter, uni, ovr;
      int unsigned s;
      int j;
      box_word o;
      s0 = it.data[15:0]; s1 = it.data[31:16];
      dl = it.data[47:32]; dt = it.data[63:48]; dr = it.data[79:64]; db = it.data[95:80];
      best = (s0 > s1) ? s0 : s1;
      lab = (s0 > s1) ? 0 : 1;
      if (best > thr_score) begin
         cx = longint'(col_cnt) * stride_cfg * 16;
         cy = longint'(row_cnt) * stride_cfg * 16;
         p = 0;
         while (p < n_boxes && !(bw[p] < best || (bw[p] == best && bc[p] > lab))) p++;
         if (n_boxes >= NBOX) begin
            ovf_seen = 1;
            if (p < NBOX) n_boxes = NBOX - 1;
         end
         if (p < NBOX) begin
            for (int m = n_boxes; m > int'(p); m--) begin
               bl[m] = bl[m-1]; bt[m] = bt[m-1]; br[m] = br[m-1]; bb[m] = bb[m-1];
               bw[m] = bw[m-1]; bc[m] = bc[m-1];
            end
            bl[p] = clip17(cx - dl); bt[p] = clip17(cy - dt);
            br[p] = clip17(cx + dr); bb[p] = clip17(cy + db);
            bw[p] = best; bc[p] = lab;
            n_boxes++;
         end
      end
      w = width_cfg;
      if (w == 0) w = 1;
      if (w > 256) w = 256;
      if (col_cnt + 1 >= w) begin
         col_cnt = 0;
         row_cnt = (row_cnt + 1) & 8'hff;
      end else col_cnt++;
      if (!it.last) return;
      // linear soft suppression, later box decays by 1 - iou
      for (int i = 0; i < int'(n_boxes); i++) begin
         j = i + 1;
         while (j < int'(n_boxes)) begin
            iw = ((br[i] < br[j]) ? br[i] : br[j]) - ((bl[i] > bl[j]) ? bl[i] : bl[j]) + 16;
            ih = ((bb[i] < bb[j]) ? bb[i] : bb[j]) - ((bt[i] > bt[j]) ? bt[i] : bt[j]) + 16;
            if (iw < 0) iw = 0;
            if (ih < 0) ih = 0;
            inter = iw * ih;
            uni = box_area(i) + box_area(j) - inter;
            s = bw[j];
            if (uni > 0 && inter * 65536 > longint'(thr_ovl) * uni) begin
               ovr = (inter * 65536) / uni;
               if (ovr > 65536) ovr = 65536;
               s = int'((longint'(s) * (65536 - ovr)) >>> 16);
               bw[j] = s;
            end
            if (s < thr_score) drop_box(j);
            else j++;
         end
      end
      if (n_boxes == 0) begin
         o.data = '0;
         o.user = {ovf_seen, 2'b00};
         o.last = 1;
         expected_boxes.push_back(o);
      end else begin
         for (int k = 0; k < int'(n_boxes); k++) begin
            o.data = {4'd0, bw[k][15:0], bb[k][16:0], br[k][16:0], bt[k][16:0], bl[k][16:0]};
            o.user = {ovf_seen, 1'b1, bc[k][0]};
            o.last = (k == int'(n_boxes) - 1);
            expected_boxes.push_back(o);
         end
      end
      row_cnt = 0; col_cnt = 0; n_boxes = 0; ovf_seen = 0;
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) decode_location('{req_tdata, req_tlast});
         if (pending_locs.size() > 0 && (tx_quiet || $urandom_range(99) >= 24)) begin
            loc_item it;
            it = pending_locs.pop_front();
            req_tdata <= it.data;
            req_tlast <= it.last;
            req_tvalid <= 1;
         end else begin
            req_tvalid <= 0;
         end
      end
   end

   // long receiver hold, started once the first word is offered after arming
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_used <= 0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end else if (hold_arm && !hold_used && rsp_tvalid) begin
         hold_left <= 3000;
         hold_used <= 1;
      end
   end

   // monitor and receiver
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            box_word e;
            boxes_seen++;
            if (rsp_tlast) maps_done++;
            if (expected_boxes.size() == 0) begin
               errors++;
               if (mismatches++ < 10) $display("unexpected word %h %b %b", rsp_tdata, rsp_tuser,
                                               rsp_tlast);
            end else begin
               e = expected_boxes.pop_front();
               if (e.data !== rsp_tdata || e.user !== rsp_tuser || e.last !== rsp_tlast) begin
                  errors++;
                  if (mismatches++ < 10)
                     $display("box mismatch: exp %h %b %b got %h %b %b", e.data, e.user, e.last,
                              rsp_tdata, rsp_tuser, rsp_tlast);
               end
            end
         end
         rsp_tready <= !rx_hold && (tx_quiet || $urandom_range(99) >= 24);
      end
   end

   // watchdog on handshake progress
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset || rx_hold)
         watch <= 0;
      else if (watch >= WATCH_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else watch <= watch + 1;
   end

   task automatic add_loc(int unsigned s0, int unsigned s1, int dl, int dt, int dr, int db,
                          bit last);
      loc_item it;
      it.data = {db[15:0], dr[15:0], dt[15:0], dl[15:0], s1[15:0], s0[15:0]};
      it.last = last;
      pending_locs.push_back(it);
   endtask

   function automatic int rnd_dist();
      case ($urandom_range(3))
         0: return int'($urandom_range(65535)) - 32768;
         1: return int'($urandom_range(32767, 32700));
         2: return -32768 + int'($urandom_range(50));
         default: return int'($urandom_range(400));
      endcase
   endfunction

   task automatic wait_drained();
      while (pending_locs.size() > 0 || req_tvalid || expected_boxes.size() > 0)
         @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, int unsigned val);
      @(posedge clock);
      csr_we <= 1; csr_addr <= idx; csr_wdata <= val[15:0];
      @(posedge clock);
      csr_we <= 0;
      case (idx)
         CSR_SCORE_THR: thr_score = val & 16'hffff;
         CSR_OVL_THR: thr_ovl = val & 16'hffff;
         CSR_MAP_WIDTH: width_cfg = val & 9'h1ff;
         default: stride_cfg = val & 6'h3f;
      endcase
   endtask

   // one map of mostly clustered boxes with random content
   task automatic random_map(int len);
      int cx;
      for (int k = 0; k < len; k++) begin
         int unsigned a, b;
         a = $urandom_range(65535);
         b = ($urandom_range(3) == 0) ? a : $urandom_range(65535);
         cx = int'($urandom_range(300));
         if ($urandom_range(3) == 0)
            add_loc(a, b, rnd_dist(), rnd_dist(), rnd_dist(), rnd_dist(), k == len - 1);
         else
            add_loc(a, b, cx, cx + 5, cx, cx + 3, k == len - 1);
      end
   endtask

   initial begin
      thr_score = 32768; thr_ovl = 26214; width_cfg = 80; stride_cfg = 4;
      row_cnt = 0; col_cnt = 0; n_boxes = 0; ovf_seen = 0;
      repeat (11) @(posedge clock);
      reset <= 0;
      // directed: extremes, ties, a map with no survivors
      add_loc(65535, 0, 32767, 32767, 32767, 32767, 0);
      add_loc(0, 65535, -32768, -32768, -32768, -32768, 0);
      add_loc(40000, 40000, 100, 100, 100, 100, 0);
      add_loc(40000, 39999, 100, 100, 100, 100, 0);
      add_loc(32768, 32768, 5, 5, 5, 5, 0);
      add_loc(50000, 1, 0, 0, 0, 0, 1);
      add_loc(0, 0, 0, 0, 0, 0, 1);
      add_loc(100, 32769, 1, 1, 1, 1, 1);
      wait_drained();
      write_reg(CSR_MAP_WIDTH, 0);
      write_reg(CSR_STRIDE, 63);
      write_reg(CSR_SCORE_THR, 0);
      write_reg(CSR_OVL_THR, 65535);
      // overflow: more candidates than the store holds, row counter wraps
      for (int k = 0; k < 300; k++)
         add_loc($urandom_range(65535), $urandom_range(65535), rnd_dist(), rnd_dist(),
                 rnd_dist(), rnd_dist(), k == 299);
      // next map waits at the input while the receiver holds off the results
      random_map(20);
      tx_quiet = 1;
      hold_arm = 1;
      wait (hold_used);
      wait (!rx_hold);
      wait_drained();
      tx_quiet = 0;
      for (int ph = 0; ph < 4; ph++) begin
         write_reg(CSR_SCORE_THR, (ph == 3) ? 65535 : $urandom_range(50000));
         write_reg(CSR_OVL_THR, (ph == 0) ? 0 : $urandom_range(65535));
         write_reg(CSR_MAP_WIDTH, (ph == 1) ? 511 : $urandom_range(256, 1));
         write_reg(CSR_STRIDE, (ph == 2) ? 0 : $urandom_range(32, 1));
         for (int m = 0; m < 5; m++) random_map($urandom_range(20, 1));
         if (ph == 1) tx_quiet = 1;
         wait_drained();
         tx_quiet = 0;
      end
      $display("covered %0d maps and %0d box words over several threshold settings", maps_done,
               boxes_seen);
      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
